// File: rtl/tgs_pkg.sv
// Shared constants for the trilinear grid sampler.
`default_nettype none
package tgs_pkg;
   localparam int GRID_X_DEF     = 16;
   localparam int GRID_Y_DEF     = 16;
   localparam int GRID_Z_DEF     = 16;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int VALUE_BITS_DEF = 16;
   localparam int CELL_BITS      = 4;
   localparam int POS_BITS       = 12;
   localparam int CORNERS        = 8;
   localparam int CORNER_BITS    = 3;
endpackage
`default_nettype wire

// File: rtl/tgs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module tgs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/tgs_blend.sv
// One linear blend step: lo*(S-w) + hi*w, rounded to nearest, ties up.
`default_nettype none
module tgs_blend #(
   parameter int VALUE_BITS = tgs_pkg::VALUE_BITS_DEF,
   parameter int FRAC_BITS  = tgs_pkg::FRAC_BITS_DEF
) (
   input  wire logic signed [VALUE_BITS-1:0] lo,
   input  wire logic signed [VALUE_BITS-1:0] hi,
   input  wire logic        [FRAC_BITS:0]    weight,
   output logic      signed [VALUE_BITS-1:0] blended
);
   localparam int TW = VALUE_BITS + FRAC_BITS + 3;

   logic signed [VALUE_BITS:0] diff;
   logic signed [TW-1:0]       prod;
   logic signed [TW-1:0]       total;

   assign diff    = (VALUE_BITS + 1)'(hi) - (VALUE_BITS + 1)'(lo);
   assign prod    = TW'(diff) * $signed(TW'(weight));
   assign total   = (TW'(lo) <<< FRAC_BITS) + prod + $signed(TW'(1) <<< (FRAC_BITS - 1));
   assign blended = VALUE_BITS'(total >>> FRAC_BITS);
endmodule
`default_nettype wire

// File: rtl/trilinear_grid_sampler.sv
// Top level of the trilinear grid sampler.
//
// Command channel: an item transfers at a rising edge with start high and
// busy low. req_kind low writes req_cell_value into cell (req_cell_x,
// req_cell_y, req_cell_z); busy stays low for the write.
// A write outside the grid is dropped. req_kind high starts a sample at
// (req_pos_x, req_pos_y, req_pos_z), unsigned with FRAC_BITS fraction bits.
// A sample reads the 8 surrounding cells from the grid RAM one per cycle
// through its one read port, waits in DRAIN for the last read, then runs
// 7 blend steps through one shared multiplier (x, then y, then z).
// rsp_strobe then pulses for one cycle with rsp_sample_value; busy is high
// from the sample transfer until then, so no new item can transfer while
// a sample is in flight. The result cannot be held off; busy drops in
// the strobe cycle so a new item may transfer then.
// Reset returns the sequencer to idle; grid contents are not cleared and
// a sample must only touch cells written before.
`default_nettype none
module trilinear_grid_sampler #(
   parameter int GRID_X     = tgs_pkg::GRID_X_DEF,
   parameter int GRID_Y     = tgs_pkg::GRID_Y_DEF,
   parameter int GRID_Z     = tgs_pkg::GRID_Z_DEF,
   parameter int FRAC_BITS  = tgs_pkg::FRAC_BITS_DEF,
   parameter int VALUE_BITS = tgs_pkg::VALUE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_kind,
   input  wire logic        [tgs_pkg::CELL_BITS-1:0] req_cell_x,
   input  wire logic        [tgs_pkg::CELL_BITS-1:0] req_cell_y,
   input  wire logic        [tgs_pkg::CELL_BITS-1:0] req_cell_z,
   input  wire logic signed [VALUE_BITS-1:0]      req_cell_value,
   input  wire logic        [tgs_pkg::POS_BITS-1:0] req_pos_x,
   input  wire logic        [tgs_pkg::POS_BITS-1:0] req_pos_y,
   input  wire logic        [tgs_pkg::POS_BITS-1:0] req_pos_z,
   output logic                                   rsp_strobe,
   output logic signed [VALUE_BITS-1:0]           rsp_sample_value
);
   import tgs_pkg::*;

   localparam int DEPTH  = GRID_X * GRID_Y * GRID_Z;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int XW     = $clog2(GRID_X);
   localparam int YW     = $clog2(GRID_Y);
   localparam int ZW     = $clog2(GRID_Z);
   localparam int WW     = FRAC_BITS + 1;

   typedef enum logic [1:0] {IDLE, READ, DRAIN, BLEND} state_type;

   state_type                      state_ff;
   logic [XW-1:0]                  bx_ff;
   logic [YW-1:0]                  by_ff;
   logic [ZW-1:0]                  bz_ff;
   logic [WW-1:0]                  wx_ff, wy_ff, wz_ff;
   logic [CORNER_BITS-1:0]         cnt_ff;
   logic                           rd_valid_ff;
   logic [CORNER_BITS-1:0]         rd_idx_ff;
   logic signed [VALUE_BITS-1:0]   queue_ff [CORNERS];
   logic [CORNER_BITS-1:0]         step_ff;
   logic                           strobe_ff;
   logic signed [VALUE_BITS-1:0]   result_ff;

   logic                           take;
   logic                           wr_en;
   logic [ADDR_W-1:0]              wr_addr;
   logic [ADDR_W-1:0]              rd_addr;
   logic [VALUE_BITS-1:0]          rd_data;
   logic [WW-1:0]                  weight;
   logic signed [VALUE_BITS-1:0]   blended;
   logic [CORNER_BITS:0]           len;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] x,
                                                    input logic [ADDR_W-1:0] y,
                                                    input logic [ADDR_W-1:0] z);
      return (x * ADDR_W'(GRID_Y) + y) * ADDR_W'(GRID_Z) + z;
   endfunction

   function automatic logic [31:0] split_base(input logic [POS_BITS-1:0] pos,
                                              input int grid);
      logic [31:0] ip;
      ip = 32'(pos >> FRAC_BITS);
      return (ip >= 32'(grid - 1)) ? 32'(grid - 2) : ip;
   endfunction

   function automatic logic [WW-1:0] split_weight(input logic [POS_BITS-1:0] pos,
                                                  input int grid);
      logic [31:0] ip;
      ip = 32'(pos >> FRAC_BITS);
      return (ip >= 32'(grid - 1)) ? (WW'(1) << FRAC_BITS) : WW'(pos[FRAC_BITS-1:0]);
   endfunction

   assign busy    = (state_ff != IDLE);
   assign take    = start && !busy;
   assign wr_en   = take && !req_kind && (32'(req_cell_x) < 32'(GRID_X))
                    && (32'(req_cell_y) < 32'(GRID_Y)) && (32'(req_cell_z) < 32'(GRID_Z));
   assign wr_addr = cell_addr(ADDR_W'(req_cell_x), ADDR_W'(req_cell_y),
                              ADDR_W'(req_cell_z));
   assign rd_addr = cell_addr(ADDR_W'(bx_ff + XW'(cnt_ff[0])),
                              ADDR_W'(by_ff + YW'(cnt_ff[1])),
                              ADDR_W'(bz_ff + ZW'(cnt_ff[2])));
   assign len     = (CORNER_BITS + 1)'(CORNERS) - (CORNER_BITS + 1)'(step_ff);
   assign weight  = (step_ff < CORNER_BITS'(4)) ? wx_ff :
                    (step_ff < CORNER_BITS'(6)) ? wy_ff : wz_ff;

   tgs_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_cell_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tgs_blend #(
      .VALUE_BITS (VALUE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_blend (
      .lo      (queue_ff[0]),
      .hi      (queue_ff[1]),
      .weight  (weight),
      .blended (blended)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         strobe_ff   <= 1'b0;
         rd_valid_ff <= 1'b0;
         cnt_ff      <= '0;
         step_ff     <= '0;
      end else begin
         strobe_ff   <= 1'b0;
         rd_valid_ff <= (state_ff == READ);
         rd_idx_ff   <= cnt_ff;
         if (rd_valid_ff) begin
            queue_ff[rd_idx_ff] <= $signed(rd_data);
         end
         case (state_ff)
            IDLE: begin
               if (take && req_kind) begin
                  bx_ff    <= XW'(split_base(req_pos_x, GRID_X));
                  by_ff    <= YW'(split_base(req_pos_y, GRID_Y));
                  bz_ff    <= ZW'(split_base(req_pos_z, GRID_Z));
                  wx_ff    <= split_weight(req_pos_x, GRID_X);
                  wy_ff    <= split_weight(req_pos_y, GRID_Y);
                  wz_ff    <= split_weight(req_pos_z, GRID_Z);
                  cnt_ff   <= '0;
                  state_ff <= READ;
               end
            end
            READ: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CORNER_BITS'(CORNERS - 1)) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               step_ff  <= '0;
               state_ff <= BLEND;
            end
            BLEND: begin
               for (int i = 0; i < CORNERS; i++) begin
                  if (i + 2 < int'(len)) begin
                     queue_ff[i] <= queue_ff[i + 2];
                  end else if (i == int'(len) - 2) begin
                     queue_ff[i] <= blended;
                  end
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == CORNER_BITS'(CORNERS - 2)) begin
                  result_ff <= blended;
                  strobe_ff <= 1'b1;
                  state_ff  <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_sample_value = result_ff;
endmodule
`default_nettype wire

// File: rtl/tgs_checker.sv
// Port-level checks for the trilinear grid sampler, bound to the top level.
`default_nettype none
module tgs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_kind,
   input wire logic rsp_strobe
);
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind |=> busy)
      else $error("sample transfer did not raise busy");

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_kind |=> !busy)
      else $error("write transfer raised busy");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(busy))
      else $error("result strobe outside the end of a sample");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");
endmodule

bind trilinear_grid_sampler tgs_checker u_tgs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_kind   (req_kind),
   .rsp_strobe (rsp_strobe)
);
`default_nettype wire
